// ===== hw/rtl/rotation_matrix_to_quaternion_unit_defines.svh =====
// assertion shorthands shared by the rtl
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RMQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmq assertion failed");

// next-cycle implication, checked outside reset
`define RMQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmq assertion failed");

`endif

// ===== hw/rtl/rmq_pkg.sv =====
package rmq_pkg;

	localparam int DATA_W        = 16;
	localparam int DIFF_W        = DATA_W + 1;
	localparam int QUO_W         = 17;
	localparam int FRAC_BITS_DEF = 14;

	localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

	// output slot of a quaternion component
	typedef enum logic [1:0] {
		SLOT_X = 2'd0,
		SLOT_Y = 2'd1,
		SLOT_Z = 2'd2,
		SLOT_W = 2'd3
	} slot_t;

endpackage

// ===== hw/rtl/rmq_mat_if.sv =====
interface rmq_mat_if;
	import rmq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] m00;
	logic signed [DATA_W-1:0] m01;
	logic signed [DATA_W-1:0] m02;
	logic signed [DATA_W-1:0] m10;
	logic signed [DATA_W-1:0] m11;
	logic signed [DATA_W-1:0] m12;
	logic signed [DATA_W-1:0] m20;
	logic signed [DATA_W-1:0] m21;
	logic signed [DATA_W-1:0] m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ===== hw/rtl/rmq_quat_if.sv =====
interface rmq_quat_if;
	import rmq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] qx;
	logic signed [DATA_W-1:0] qy;
	logic signed [DATA_W-1:0] qz;
	logic signed [DATA_W-1:0] qw;
	logic                     degenerate;

	modport source (output valid, qx, qy, qz, qw, degenerate, input ready);
	modport sink   (input valid, qx, qy, qz, qw, degenerate, output ready);
endinterface

// ===== hw/rtl/rotation_matrix_to_quaternion_unit.sv =====
// rotation matrix to unit quaternion, Shepperd's method, fixed point
// mat  : sink channel, one word = nine signed matrix elements with FRAC_BITS fraction bits
// quat : source channel, one word = qx qy qz qw (saturated) and the degenerate flag
// throughput: one word per cycle while quat is not stalled; every stage may take a
//   new word each clock. Stages: the front, the bit-serial square root (one stage per
//   root bit), the divider set-up, the restoring divider (one stage per quotient bit,
//   17 of them) and the output register
// each stage holds a valid bit; a stage loads whenever it is empty or the stage
//   after it moves, so bubbles close up and mat.ready stays high until every
//   stage is full and quat is stalled
// a stall of quat freezes only full stages; nothing is lost or repeated
// reset clears all valid bits; the datapath registers are not reset
// degenerate words (non-positive radicand) come out with all components zero
`include "rotation_matrix_to_quaternion_unit_defines.svh"

module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rmq_mat_if.sink     mat,
	rmq_quat_if.source  quat
);
	import rmq_pkg::*;

	// radicand width, even-rounded root input width, root width, divisor width
	localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
	localparam int NW0  = RW + FRAC_BITS - 2;
	localparam int NW   = NW0 + (NW0 % 2);
	localparam int SQ_W = NW / 2;
	localparam int DW   = SQ_W + 2;
	localparam int RMW  = ((DW + QUO_W > FRAC_BITS + QUO_W + 1) ?
		(DW + QUO_W) : (FRAC_BITS + QUO_W + 1)) + 1;
	localparam int NS   = SQ_W + 3 + QUO_W;

	localparam logic signed [RW:0] ONE_R = (RW + 1)'(1) << FRAC_BITS;

	typedef struct packed {
		logic [NW-1:0]                n;
		logic [NW-1:0]                res;
		slot_t                        slot;
		logic                         degen;
		logic [3:0][DIFF_W-1:0]       d;
	} sq_t;

	typedef struct packed {
		logic [SQ_W-1:0]              main;
		slot_t                        slot;
		logic                         degen;
		logic [3:0]                   neg;
		logic [3:0]                   ovf;
		logic [3:0][RMW-1:0]          rem;
		logic [3:0][QUO_W-1:0]        quo;
	} dv_t;

	logic [NS-1:0] v_s;   // valid bit of every stage
	logic [NS-1:0] en;    // stage may load

	sq_t sq_s [SQ_W+1];
	dv_t dv_s [QUO_W+1];
	logic signed [3:0][DATA_W-1:0] quat_s;
	logic                          degen_s;

	// handshake chain: a stage loads when empty or when its successor moves
	assign en[NS-1] = !v_s[NS-1] || quat.ready;
	for (genvar i = 0; i < NS - 1; i++) begin : g_en
		assign en[i] = !v_s[i] || en[i+1];
	end
	assign mat.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) begin
				v_s[0] <= mat.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					v_s[i] <= v_s[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------- front
	// trace test, axis choice, radicand and the three off-diagonal terms
	logic signed [DATA_W+1:0] trace;
	logic signed [RW:0]       r_t;
	logic signed [RW:0]       r_nt;
	logic signed [RW:0]       r_sel;
	logic signed [DATA_W-1:0] mii;
	logic signed [DATA_W-1:0] mjj;
	logic signed [DATA_W-1:0] mkk;
	slot_t                    axis;
	sq_t                      front;

	always_comb begin
		trace = (DATA_W + 2)'(mat.m00) + (DATA_W + 2)'(mat.m11) + (DATA_W + 2)'(mat.m22);
		r_t   = (RW + 1)'(trace) + ONE_R;

		// strict compare, so the lower index wins a tie
		axis = SLOT_X;
		mii  = mat.m00;
		if (mat.m11 > mat.m00) begin
			axis = SLOT_Y;
			mii  = mat.m11;
		end
		if (mat.m22 > mii) begin
			axis = SLOT_Z;
			mii  = mat.m22;
		end

		front       = '0;
		front.res   = '0;
		front.degen = 1'b0;
		case (axis)
			SLOT_X: begin
				mjj        = mat.m11;
				mkk        = mat.m22;
				front.d[SLOT_W] = DIFF_W'(mat.m21) - DIFF_W'(mat.m12);
				front.d[SLOT_Y] = DIFF_W'(mat.m10) + DIFF_W'(mat.m01);
				front.d[SLOT_Z] = DIFF_W'(mat.m20) + DIFF_W'(mat.m02);
			end
			SLOT_Y: begin
				mjj        = mat.m22;
				mkk        = mat.m00;
				front.d[SLOT_W] = DIFF_W'(mat.m02) - DIFF_W'(mat.m20);
				front.d[SLOT_Z] = DIFF_W'(mat.m21) + DIFF_W'(mat.m12);
				front.d[SLOT_X] = DIFF_W'(mat.m01) + DIFF_W'(mat.m10);
			end
			default: begin
				mjj        = mat.m00;
				mkk        = mat.m11;
				front.d[SLOT_W] = DIFF_W'(mat.m10) - DIFF_W'(mat.m01);
				front.d[SLOT_X] = DIFF_W'(mat.m02) + DIFF_W'(mat.m20);
				front.d[SLOT_Y] = DIFF_W'(mat.m12) + DIFF_W'(mat.m21);
			end
		endcase
		r_nt = (RW + 1)'(mii) - (RW + 1)'(mjj) - (RW + 1)'(mkk) + ONE_R;

		if (trace > 0) begin
			front.slot      = SLOT_W;
			r_sel           = r_t;
			front.d[SLOT_X] = DIFF_W'(mat.m21) - DIFF_W'(mat.m12);
			front.d[SLOT_Y] = DIFF_W'(mat.m02) - DIFF_W'(mat.m20);
			front.d[SLOT_Z] = DIFF_W'(mat.m10) - DIFF_W'(mat.m01);
			front.d[SLOT_W] = '0;
		end else begin
			front.slot  = axis;
			r_sel       = r_nt;
			front.degen = (r_nt <= 0);
		end
		front.n = NW'(r_sel[RW-1:0]) << (FRAC_BITS - 2);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_s[0] <= front;
		end
	end

	// ---------------------------------------------------------- square root
	// one result bit per stage, digit-by-digit over the scaled radicand
	for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
		localparam logic [NW:0] BIT = (NW + 1)'(1) << (2 * (SQ_W - 1 - k));
		logic [NW:0] trial;
		sq_t         nxt;

		always_comb begin
			nxt   = sq_s[k];
			trial = {1'b0, sq_s[k].res} + BIT;
			if ({1'b0, sq_s[k].n} >= trial) begin
				nxt.n   = sq_s[k].n - trial[NW-1:0];
				nxt.res = (sq_s[k].res >> 1) + BIT[NW-1:0];
			end else begin
				nxt.res = sq_s[k].res >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// ------------------------------------------------------- divider set-up
	// numerator = |d| * 2^F + 2*main (rounding), divisor = 4*main
	dv_t                 dv_init;
	logic [DIFF_W-1:0]   mag [4];

	always_comb begin
		dv_init       = '0;
		dv_init.main  = sq_s[SQ_W].res[SQ_W-1:0];
		dv_init.slot  = sq_s[SQ_W].slot;
		dv_init.degen = sq_s[SQ_W].degen;
		for (int c = 0; c < 4; c++) begin
			dv_init.neg[c] = sq_s[SQ_W].d[c][DIFF_W-1];
			mag[c] = dv_init.neg[c] ? (DIFF_W'(0) - sq_s[SQ_W].d[c]) : sq_s[SQ_W].d[c];
			dv_init.rem[c] = (RMW'(mag[c]) << FRAC_BITS) + (RMW'(dv_init.main) << 1);
			// quotient would need more than QUO_W bits: saturates anyway
			dv_init.ovf[c] = dv_init.rem[c] >= (RMW'(dv_init.main) << (QUO_W + 2));
		end
	end

	always_ff @(posedge clk) begin
		if (en[SQ_W+1]) begin
			dv_s[0] <= dv_init;
		end
	end

	// -------------------------------------------------------------- divider
	// restoring division, one quotient bit per stage, four lanes side by side
	for (genvar b = 0; b < QUO_W; b++) begin : g_div
		localparam int P = QUO_W - 1 - b;
		logic [RMW-1:0] dsh;
		dv_t            nxt;

		always_comb begin
			nxt = dv_s[b];
			dsh = RMW'(dv_s[b].main) << (P + 2);
			for (int c = 0; c < 4; c++) begin
				if (dv_s[b].rem[c] >= dsh) begin
					nxt.rem[c]    = dv_s[b].rem[c] - dsh;
					nxt.quo[c][P] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[SQ_W+2+b]) begin
				dv_s[b+1] <= nxt;
			end
		end
	end

	// ------------------------------------------------------ output register
	logic signed [3:0][DATA_W-1:0] comp;
	dv_t                           fin;

	always_comb begin
		fin = dv_s[QUO_W];
		for (int c = 0; c < 4; c++) begin
			if (fin.degen) begin
				comp[c] = '0;
			end else if (slot_t'(c) == fin.slot) begin
				comp[c] = (32'(fin.main) > 32'(Q_MAX)) ? Q_MAX : DATA_W'(fin.main);
			end else if (fin.neg[c]) begin
				comp[c] = (fin.ovf[c] || fin.quo[c] > QUO_W'(32768)) ?
					Q_MIN : (DATA_W'(0) - DATA_W'(fin.quo[c]));
			end else begin
				comp[c] = (fin.ovf[c] || fin.quo[c] > QUO_W'(32767)) ?
					Q_MAX : DATA_W'(fin.quo[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			quat_s  <= comp;
			degen_s <= fin.degen;
		end
	end

	assign quat.valid      = v_s[NS-1];
	assign quat.qx         = quat_s[SLOT_X];
	assign quat.qy         = quat_s[SLOT_Y];
	assign quat.qz         = quat_s[SLOT_Z];
	assign quat.qw         = quat_s[SLOT_W];
	assign quat.degenerate = degen_s;

	// ------------------------------------------------------------ checks
	`RMQ_ASSERT_IMP(a_degen_zero, quat.valid && quat.degenerate,
		quat.qx == 0 && quat.qy == 0 && quat.qz == 0 && quat.qw == 0)
	`RMQ_ASSERT_IMP(a_backpressure_cause, !mat.ready, quat.valid && !quat.ready)
	`RMQ_ASSERT_NEXT(a_out_load, en[NS-1] && v_s[NS-2], quat.valid)

endmodule

// ===== bench/rotation_matrix_to_quaternion_unit_tb.sv =====
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit_tb;
	import rmq_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int ONE = 1 << FRAC;
	// wait scale for the receiver hold-off and the final drain
	localparam int DEPTH = 35;

	typedef struct packed {
		logic signed [DATA_W-1:0] qx;
		logic signed [DATA_W-1:0] qy;
		logic signed [DATA_W-1:0] qz;
		logic signed [DATA_W-1:0] qw;
		logic                     degenerate;
	} quat_t;

	typedef logic signed [DATA_W-1:0] mat_t [3][3];

	logic clk;
	logic arst_n;

	rmq_mat_if  mat ();
	rmq_quat_if quat ();

	rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat),
		.quat   (quat)
	);

	// quaternions still owed by the block, oldest first
	quat_t owed_quats[$];
	int    mismatches;
	int    words_checked;

	// idle percentages, changed between phases
	int send_idle_pct;
	int recv_idle_pct;
	// long receiver hold-off, counted down in its own process
	int hold_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// floor of the square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   -= res + bitv;
				res  = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [DATA_W-1:0] clip16(input longint v);
		if (v > 32767)
			return Q_MAX;
		if (v < -32768)
			return Q_MIN;
		return v[DATA_W-1:0];
	endfunction

	// d scaled up by 2^FRAC over den, rounded half away from zero
	function automatic longint div_round(input longint d, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (d < 0) ? longint'(-d) : d;
		q   = ((mag << FRAC) + den / 2) / den;
		if (q > 65536)
			q = 65536;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic quat_t quat_of_matrix(input mat_t mm);
		longint m [3][3];
		longint q [4];
		longint tr;
		longint rad;
		longint unsigned root;
		longint unsigned den;
		int i;
		int j;
		int k;
		quat_t res;
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				m[a][b] = mm[a][b];
		for (int a = 0; a < 4; a++)
			q[a] = 0;
		res.degenerate = 1'b0;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			rad  = tr + ONE;
			root = int_sqrt(longint'(rad) << (FRAC - 2));
			den  = 4 * root;
			q[SLOT_W] = root;
			q[SLOT_X] = div_round(m[2][1] - m[1][2], den);
			q[SLOT_Y] = div_round(m[0][2] - m[2][0], den);
			q[SLOT_Z] = div_round(m[1][0] - m[0][1], den);
		end else begin
			// ties on the diagonal keep the lower axis
			i = 0;
			if (m[1][1] > m[0][0])
				i = 1;
			if (m[2][2] > m[i][i])
				i = 2;
			j   = (i + 1) % 3;
			k   = (j + 1) % 3;
			rad = m[i][i] - (m[j][j] + m[k][k]) + ONE;
			if (rad <= 0) begin
				res.degenerate = 1'b1;
			end else begin
				root = int_sqrt(longint'(rad) << (FRAC - 2));
				den  = 4 * root;
				q[i]      = root;
				q[SLOT_W] = div_round(m[k][j] - m[j][k], den);
				q[j]      = div_round(m[j][i] + m[i][j], den);
				q[k]      = div_round(m[k][i] + m[i][k], den);
			end
		end
		res.qx = clip16(q[SLOT_X]);
		res.qy = clip16(q[SLOT_Y]);
		res.qz = clip16(q[SLOT_Z]);
		res.qw = clip16(q[SLOT_W]);
		return res;
	endfunction

	// ---------------------------------------------------------------- sender

	// valid stays high between back-to-back words and drops only while idling
	task automatic send_matrix(input mat_t mm);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			mat.valid <= 1'b0;
			@(posedge clk);
		end
		mat.valid <= 1'b1;
		mat.m00 <= mm[0][0]; mat.m01 <= mm[0][1]; mat.m02 <= mm[0][2];
		mat.m10 <= mm[1][0]; mat.m11 <= mm[1][1]; mat.m12 <= mm[1][2];
		mat.m20 <= mm[2][0]; mat.m21 <= mm[2][1]; mat.m22 <= mm[2][2];
		@(posedge clk);
		while (!mat.ready)
			@(posedge clk);
		// word accepted at this edge
		owed_quats.push_back(quat_of_matrix(mm));
	endtask

	// ---------------------------------------------------------------- receiver

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			quat.ready  <= 1'b0;
		end else begin
			quat.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch word %0d %s: got %0d expected %0d", words_checked, what, got, want);
	endtask

	// compare each accepted quaternion with the oldest one owed
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && quat.valid && quat.ready) begin
			if (owed_quats.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = owed_quats.pop_front();
				if (quat.qx !== want.qx)
					report_mismatch("qx", quat.qx, want.qx);
				if (quat.qy !== want.qy)
					report_mismatch("qy", quat.qy, want.qy);
				if (quat.qz !== want.qz)
					report_mismatch("qz", quat.qz, want.qz);
				if (quat.qw !== want.qw)
					report_mismatch("qw", quat.qw, want.qw);
				if (quat.degenerate !== want.degenerate)
					report_mismatch("degenerate", quat.degenerate, want.degenerate);
			end
			words_checked++;
		end
	end

	// ---------------------------------------------------------------- matrices

	function automatic mat_t diag_matrix(input int a, input int b, input int c);
		mat_t mm;
		for (int r = 0; r < 3; r++)
			for (int s = 0; s < 3; s++)
				mm[r][s] = '0;
		mm[0][0] = DATA_W'(a);
		mm[1][1] = DATA_W'(b);
		mm[2][2] = DATA_W'(c);
		return mm;
	endfunction

	function automatic mat_t noise_matrix();
		mat_t mm;
		for (int r = 0; r < 3; r++)
			for (int s = 0; s < 3; s++)
				mm[r][s] = DATA_W'($urandom);
		return mm;
	endfunction

	// proper rotation from a random unit quaternion, with a little jitter
	function automatic mat_t rotation_matrix();
		real a;
		real b;
		real c;
		real d;
		real n;
		real r [3][3];
		mat_t mm;
		a = real'($urandom_range(20000)) - 10000.0;
		b = real'($urandom_range(20000)) - 10000.0;
		c = real'($urandom_range(20000)) - 10000.0;
		d = real'($urandom_range(20000)) - 10000.0;
		n = $sqrt(a*a + b*b + c*c + d*d) + 1.0e-9;
		a /= n; b /= n; c /= n; d /= n;
		// a = w, b = x, c = y, d = z
		r[0][0] = 1 - 2*(c*c + d*d); r[0][1] = 2*(b*c - d*a); r[0][2] = 2*(b*d + c*a);
		r[1][0] = 2*(b*c + d*a); r[1][1] = 1 - 2*(b*b + d*d); r[1][2] = 2*(c*d - b*a);
		r[2][0] = 2*(b*d - c*a); r[2][1] = 2*(c*d + b*a); r[2][2] = 1 - 2*(b*b + c*c);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				mm[i][j] = DATA_W'($rtoi(r[i][j] * ONE) + int'($urandom_range(8)) - 4);
		return mm;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		mat_t mm;
		send_matrix(diag_matrix(ONE, ONE, ONE));          // identity, positive trace
		send_matrix(diag_matrix(ONE, -ONE, -ONE));        // half turn about x
		send_matrix(diag_matrix(-ONE, ONE, -ONE));        // half turn about y
		send_matrix(diag_matrix(-ONE, -ONE, ONE));        // half turn about z
		send_matrix(diag_matrix(0, 0, 0));                // zero trace, tie on diagonal
		send_matrix(diag_matrix(-ONE, -ONE, -ONE));       // tie, radicand 2*ONE
		send_matrix(diag_matrix(-32768, -32768, -32768)); // most negative diagonal, tie keeps x
		send_matrix(diag_matrix(32767, 32767, 32767));    // largest trace
		send_matrix(diag_matrix(-5, -5, 3));              // z wins by a hair
		send_matrix(diag_matrix(-5, -3, -3));             // y/z tie keeps y
		send_matrix(diag_matrix(0, 0, 1));                // trace just positive
		// off-diagonal extremes; the first, with a small radicand, gives saturating quotients
		mm = diag_matrix(1, 0, 0);
		mm[0][1] = 16'sh8000; mm[1][0] = 16'sh7fff;
		mm[2][1] = 16'sh7fff; mm[1][2] = 16'sh8000;
		mm[0][2] = 16'sh8000; mm[2][0] = 16'sh7fff;
		send_matrix(mm);
		mm = diag_matrix(16'sh8000, 16'sh8000, 16'sh7fff);
		mm[0][1] = 16'sh7fff; mm[1][0] = 16'sh7fff;
		mm[2][1] = 16'sh8000; mm[1][2] = 16'sh7fff;
		mm[0][2] = 16'sh7fff; mm[2][0] = 16'sh7fff;
		send_matrix(mm);
		// all ones pattern and quarter turns
		for (int r = 0; r < 3; r++)
			for (int s = 0; s < 3; s++)
				mm[r][s] = 16'shffff;
		send_matrix(mm);
		mm = diag_matrix(0, 0, ONE);
		mm[0][1] = DATA_W'(-ONE); mm[1][0] = DATA_W'(ONE);
		send_matrix(mm);
		mm = diag_matrix(ONE, 0, 0);
		mm[1][2] = DATA_W'(ONE); mm[2][1] = DATA_W'(-ONE);
		send_matrix(mm);
	endtask

	task automatic test_random(input int words);
		for (int n = 0; n < words; n++)
			send_matrix(($urandom_range(99) < 75) ? rotation_matrix() : noise_matrix());
	endtask

	// receiver stops for a long while so the pipeline fills and mat.ready drops
	task automatic test_backpressure();
		hold_cycles = 3 * DEPTH;
		test_random(60);
	endtask

	task automatic wait_drained();
		mat.valid <= 1'b0;
		while (owed_quats.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 5) @(posedge clk);
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		mat.valid     = 1'b0;
		mat.m00 = '0; mat.m01 = '0; mat.m02 = '0;
		mat.m10 = '0; mat.m11 = '0; mat.m12 = '0;
		mat.m20 = '0; mat.m21 = '0; mat.m22 = '0;
		quat.ready    = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 47;
		hold_cycles   = 0;
		mismatches    = 0;
		words_checked = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(170);
		send_idle_pct = 47;
		recv_idle_pct = 31;
		test_random(150);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(150);
		wait_drained();

		if (mismatches == 0 && owed_quats.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// generous guard: every word at worst gaps and stalls
	initial begin
		#(8 * 200000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
